// ===== hw/rtl/lrc_pkg.sv =====
// Package for the laser line row-center block: field widths, register
// indexes, reset values and the quarter-wave sine table with its interpolator.
// No dependencies.
package lrc_pkg;

	localparam int RED_W = 8;
	localparam int STEP_W = 16;
	localparam int PHASE_W = 16;
	localparam int POINT_W = 16;
	localparam int ZW = 11;
	localparam int TRIG_W = 16;
	localparam int TRIG_MAG_W = 15;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_RED_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP = 1'd1;

	localparam logic [RED_W-1:0] RED_THRESHOLD_RESET = 8'd200;
	localparam logic [STEP_W-1:0] ANGLE_STEP_RESET = 16'd1024;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

	// Sine of k * pi / 128 in Q14 for k = 0..64.
	function automatic logic [TRIG_MAG_W-1:0] quarter_sine(input logic [6:0] k);
		logic [TRIG_MAG_W-1:0] v;
		case (k)
			7'd0: v = 15'd0;          7'd1: v = 15'd402;    7'd2: v = 15'd804;
			7'd3: v = 15'd1205;       7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
			7'd6: v = 15'd2404;       7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
			7'd9: v = 15'd3590;       7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
			7'd12: v = 15'd4756;      7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
			7'd15: v = 15'd5897;      7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
			7'd18: v = 15'd7005;      7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
			7'd21: v = 15'd8076;      7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
			7'd24: v = 15'd9102;      7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
			7'd27: v = 15'd10080;     7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
			7'd30: v = 15'd11003;     7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
			7'd33: v = 15'd11866;     7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
			7'd36: v = 15'd12665;     7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
			7'd39: v = 15'd13395;     7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
			7'd42: v = 15'd14053;     7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
			7'd45: v = 15'd14635;     7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
			7'd48: v = 15'd15137;     7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
			7'd51: v = 15'd15557;     7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
			7'd54: v = 15'd15893;     7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
			7'd57: v = 15'd16143;     7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
			7'd60: v = 15'd16305;     7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
			7'd63: v = 15'd16379;     7'd64: v = 15'd16384;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// Q14 sine of a 16-bit phase with linear interpolation between table points.
	function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [PHASE_W-1:0] phase);
		logic [1:0] quad;
		logic [14:0] r;
		logic [6:0] idx;
		logic [7:0] frac;
		logic [TRIG_MAG_W-1:0] t0;
		logic [TRIG_MAG_W-1:0] t1;
		logic [8:0] d;
		logic [17:0] step;
		logic [TRIG_MAG_W-1:0] mag;
		quad = phase[15:14];
		r = {1'b0, phase[13:0]};
		if (quad[0]) begin
			r = 15'h4000 - r;
		end
		idx = r[14:8];
		frac = r[7:0];
		t0 = quarter_sine(idx);
		t1 = quarter_sine(idx + 7'd1);
		d = 9'(t1 - t0);
		step = 18'(d) * 18'(frac) + 18'd128;
		if (idx[6]) begin
			mag = quarter_sine(7'd64);
		end else begin
			mag = t0 + TRIG_MAG_W'(step[17:8]);
		end
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

// ===== hw/rtl/lrc_pixel_if.sv =====
// Pixel channel of the laser line row-center block: valid, ready and one pixel.
// Depends on lrc_pkg.
interface lrc_pixel_if;
	logic valid;
	logic ready;
	logic [lrc_pkg::RED_W-1:0] red_level;
	logic row_last;
	logic frame_last;

	modport source(output valid, red_level, row_last, frame_last, input ready);
	modport sink(input valid, red_level, row_last, frame_last, output ready);
endinterface

// ===== hw/rtl/lrc_point_if.sv =====
// Point channel of the laser line row-center block: valid, ready and one point.
// Depends on lrc_pkg.
interface lrc_point_if;
	logic valid;
	logic ready;
	logic signed [lrc_pkg::POINT_W-1:0] point_x;
	logic signed [lrc_pkg::POINT_W-1:0] point_y;
	logic [lrc_pkg::ZW-1:0] point_z;

	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== hw/rtl/lrc_trig.sv =====
// Registered sine and cosine of a turntable phase in Q14.
// Depends on lrc_pkg for the table and the interpolator.
module lrc_trig (
	input  logic clk,
	input  logic en,
	input  logic [lrc_pkg::PHASE_W-1:0] phase,
	output logic signed [lrc_pkg::TRIG_W-1:0] sin_s2,
	output logic signed [lrc_pkg::TRIG_W-1:0] cos_s2
);
	import lrc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2 <= sine_q14(phase);
			cos_s2 <= sine_q14(phase + QUARTER_TURN);
		end
	end

endmodule

// ===== hw/rtl/laser_line_row_center_rotate.sv =====
// Laser line row-center extraction with turntable rotation, top level.
// Depends on lrc_pkg, lrc_pixel_if, lrc_point_if and lrc_trig.
//
// Pixels enter on pix in raster order, one item per clock when pt is not
// stalled. Each pixel is compared against red_threshold; per row the block
// finds the first lit column (column zero excluded) and the first dark
// column after it. The pixel that ends a row, or the frame, yields one point
// on pt when such a run was found: the run midpoint rotated by the turntable
// angle, x and y in Q4, and the row index as z.
// A point passes through the s1, s2 and s3 registers and the output register
// before it is valid on pt; the row tracker takes one pixel per cycle while pt is not stalled.
// When pt stalls with a point waiting, the whole pipeline holds and pix.ready
// drops until the point is taken.
// The angle advances by angle_step after each frame-end pixel. Registers must
// be written through cfg_we, cfg_index and cfg_wdata while the block is idle;
// the block does not enforce this. Reset clears the row tracker, the angle and
// the pipeline, and loads red_threshold with 200 and angle_step with 1024.
module laser_line_row_center_rotate #(
	parameter int MAX_WIDTH = lrc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lrc_pkg::MAX_HEIGHT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lrc_pixel_if.sink pix,
	lrc_point_if.source pt
);
	import lrc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = CW + TRIG_MAG_W;

	logic [RED_W-1:0] red_threshold_q;
	logic [STEP_W-1:0] angle_step_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] run_start_q;
	logic [CW-1:0] run_end_q;
	logic end_seen_q;
	logic [PHASE_W-1:0] angle_phase_q;

	logic en;
	logic acc;
	logic lit;
	logic row_done;
	logic hit;
	logic [CW-1:0] start_n;
	logic [CW-1:0] end_n;
	logic seen_n;
	logic [CW-1:0] mid;

	logic valid_s1;
	logic [CW-1:0] m_s1;
	logic [ZW-1:0] z_s1;
	logic [PHASE_W-1:0] phase_s1;

	logic valid_s2;
	logic [CW-1:0] m_s2;
	logic [ZW-1:0] z_s2;
	logic signed [TRIG_W-1:0] sin_s2;
	logic signed [TRIG_W-1:0] cos_s2;
	logic [TRIG_MAG_W-1:0] sin_mag;
	logic [TRIG_MAG_W-1:0] cos_mag;

	logic valid_s3;
	logic [PW-1:0] prod_x_s3;
	logic [PW-1:0] prod_y_s3;
	logic neg_x_s3;
	logic neg_y_s3;
	logic [ZW-1:0] z_s3;

	logic out_valid_q;
	logic signed [POINT_W-1:0] point_x_q;
	logic signed [POINT_W-1:0] point_y_q;
	logic [ZW-1:0] point_z_q;

	// Round a Q14 magnitude product to Q4, apply the sign and saturate.
	function automatic logic signed [POINT_W-1:0] to_q4(input logic [PW-1:0] prod,
			input logic neg);
		logic [PW:0] sum;
		logic [31:0] mag;
		logic signed [POINT_W-1:0] v;
		sum = {1'b0, prod} + (PW + 1)'(512);
		mag = 32'(sum[PW:10]);
		if (neg) begin
			v = (mag > 32'd32768) ? POINT_W'(-32768) : -POINT_W'(mag);
		end else begin
			v = (mag > 32'd32767) ? POINT_W'(32767) : POINT_W'(mag);
		end
		return v;
	endfunction

	assign en = !out_valid_q || pt.ready;
	assign pix.ready = en;
	assign acc = pix.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_threshold_q <= RED_THRESHOLD_RESET;
			angle_step_q <= ANGLE_STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_THRESHOLD: red_threshold_q <= cfg_wdata[RED_W-1:0];
				REG_ANGLE_STEP: angle_step_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lit = pix.red_level > red_threshold_q;
		start_n = run_start_q;
		end_n = run_end_q;
		seen_n = end_seen_q;
		if (lit && run_start_q == '0) begin
			start_n = col_q;
		end
		if (!lit && run_start_q != '0 && !end_seen_q) begin
			end_n = col_q;
			seen_n = 1'b1;
		end
		row_done = pix.row_last || pix.frame_last;
		hit = row_done && start_n != '0 && seen_n && end_n > start_n;
		mid = start_n + ((end_n - start_n) >> 1);
	end

	// Row tracker: column, row, run bounds and turntable angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			run_start_q <= '0;
			run_end_q <= '0;
			end_seen_q <= 1'b0;
			angle_phase_q <= '0;
		end else if (acc) begin
			if (row_done) begin
				col_q <= '0;
				run_start_q <= '0;
				run_end_q <= '0;
				end_seen_q <= 1'b0;
				if (pix.frame_last) begin
					row_q <= '0;
					angle_phase_q <= angle_phase_q + angle_step_q;
				end else if (row_q < RW'(MAX_HEIGHT - 1)) begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				run_start_q <= start_n;
				run_end_q <= end_n;
				end_seen_q <= seen_n;
				if (col_q < CW'(MAX_WIDTH - 1)) begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc && hit;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mid;
			z_s1 <= ZW'(row_q);
			phase_s1 <= angle_phase_q;
			m_s2 <= m_s1;
			z_s2 <= z_s1;
			prod_x_s3 <= PW'(m_s2) * PW'(cos_mag);
			prod_y_s3 <= PW'(m_s2) * PW'(sin_mag);
			neg_x_s3 <= cos_s2[TRIG_W-1];
			neg_y_s3 <= sin_s2[TRIG_W-1];
			z_s3 <= z_s2;
			point_x_q <= to_q4(prod_x_s3, neg_x_s3);
			point_y_q <= to_q4(prod_y_s3, neg_y_s3);
			point_z_q <= z_s3;
		end
	end

	lrc_trig u_trig (
		.clk(clk),
		.en(en),
		.phase(phase_s1),
		.sin_s2(sin_s2),
		.cos_s2(cos_s2)
	);

	assign sin_mag = sin_s2[TRIG_W-1] ? TRIG_MAG_W'(-sin_s2) : TRIG_MAG_W'(sin_s2);
	assign cos_mag = cos_s2[TRIG_W-1] ? TRIG_MAG_W'(-cos_s2) : TRIG_MAG_W'(cos_s2);

	assign pt.valid = out_valid_q;
	assign pt.point_x = point_x_q;
	assign pt.point_y = point_y_q;
	assign pt.point_z = point_z_q;

`ifndef SYNTHESIS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(MAX_WIDTH - 1))
		else $error("column counter past the row limit");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(MAX_HEIGHT - 1))
		else $error("row counter past the frame limit");
	a_frame_clears_row: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pix.frame_last |=> row_q == '0 && col_q == '0)
		else $error("frame end did not restart the row and column counters");
	a_end_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		end_seen_q |-> run_start_q != '0)
		else $error("run end recorded without a run start");
	a_point_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s3))
		else $error("point appeared without a pipeline item behind it");
`endif

endmodule
